// ===== hw/rtl/line_rasterizer_defines.svh =====
// Assertion macros shared by the line rasterizer RTL.
// Expects i_clk and i_rst_n in the scope where a macro is used.
`ifndef LINE_RASTERIZER_DEFINES_SVH
`define LINE_RASTERIZER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define LR_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define LR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/lr_pkg.sv =====
// Shared types and constants for the line rasterizer.
// No dependencies; used by the channel interfaces and all modules.
package lr_pkg;

    localparam int LR_COORD_BITS = 12;
    localparam int LR_COLOUR_BITS = 8;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_STEP = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        DIR_NONE = 2'd0,
        DIR_INC  = 2'd1,
        DIR_DEC  = 2'd3
    } t_minor_dir;

    typedef struct packed {
        logic       y_major;
        t_minor_dir minor_dir;
    } t_line_ctrl;

endpackage

// ===== hw/rtl/lr_in_if.sv =====
// Command channel of the line rasterizer: load or step items.
// Depends on lr_pkg.
interface lr_in_if #(
    parameter int COORD_BITS = lr_pkg::LR_COORD_BITS
) ();
    import lr_pkg::*;

    logic                             valid;
    logic                             ready;
    t_op                              op;
    logic signed [COORD_BITS-1:0]     start_x;
    logic signed [COORD_BITS-1:0]     start_y;
    logic signed [COORD_BITS-1:0]     end_x;
    logic signed [COORD_BITS-1:0]     end_y;
    logic        [LR_COLOUR_BITS-1:0] colour;

    modport source (
        output valid, op, start_x, start_y, end_x, end_y, colour,
        input  ready
    );

    modport sink (
        input  valid, op, start_x, start_y, end_x, end_y, colour,
        output ready
    );

endinterface

// ===== hw/rtl/lr_pix_if.sv =====
// Pixel channel of the line rasterizer: one transfer per emitted pixel.
// Depends on lr_pkg.
interface lr_pix_if #(
    parameter int COORD_BITS = lr_pkg::LR_COORD_BITS
) ();
    import lr_pkg::*;

    logic                             valid;
    logic                             ready;
    logic signed [COORD_BITS-1:0]     pixel_x;
    logic signed [COORD_BITS-1:0]     pixel_y;
    logic        [LR_COLOUR_BITS-1:0] pixel_colour;
    logic                             last_pixel;

    modport source (
        output valid, pixel_x, pixel_y, pixel_colour, last_pixel,
        input  ready
    );

    modport sink (
        input  valid, pixel_x, pixel_y, pixel_colour, last_pixel,
        output ready
    );

endinterface

// ===== hw/rtl/lr_setup.sv =====
// Line setup: major axis choice, endpoint ordering and error terms.
// Purely combinational; depends on lr_pkg.
module lr_setup #(
    parameter int COORD_BITS = lr_pkg::LR_COORD_BITS
) (
    input  logic signed [COORD_BITS-1:0] i_start_x,
    input  logic signed [COORD_BITS-1:0] i_start_y,
    input  logic signed [COORD_BITS-1:0] i_end_x,
    input  logic signed [COORD_BITS-1:0] i_end_y,
    output lr_pkg::t_line_ctrl           o_ctrl,
    output logic signed [COORD_BITS-1:0] o_cur_major,
    output logic signed [COORD_BITS-1:0] o_cur_minor,
    output logic signed [COORD_BITS-1:0] o_stop_major,
    output logic        [COORD_BITS:0]   o_err_limit,
    output logic        [COORD_BITS:0]   o_err_inc
);
    import lr_pkg::*;

    localparam int ERR_W = COORD_BITS + 1;

    logic [ERR_W-1:0]             diff_x;
    logic [ERR_W-1:0]             diff_y;
    logic [ERR_W-1:0]             abs_x;
    logic [ERR_W-1:0]             abs_y;
    logic [ERR_W-1:0]             d_major;
    logic [ERR_W-1:0]             d_minor;
    logic                         y_major;
    logic                         swap;
    logic signed [COORD_BITS-1:0] ma0;
    logic signed [COORD_BITS-1:0] mi0;
    logic signed [COORD_BITS-1:0] ma1;
    logic signed [COORD_BITS-1:0] mi1;
    logic signed [COORD_BITS-1:0] mi_first;
    logic signed [COORD_BITS-1:0] mi_stop;

    // One extra bit keeps the difference exact.
    assign diff_x = {i_start_x[COORD_BITS-1], i_start_x} - {i_end_x[COORD_BITS-1], i_end_x};
    assign diff_y = {i_start_y[COORD_BITS-1], i_start_y} - {i_end_y[COORD_BITS-1], i_end_y};
    assign abs_x  = diff_x[ERR_W-1] ? (~diff_x + ERR_W'(1)) : diff_x;
    assign abs_y  = diff_y[ERR_W-1] ? (~diff_y + ERR_W'(1)) : diff_y;

    // Ties go to the x axis.
    assign y_major = abs_y > abs_x;

    always_comb begin
        if (y_major) begin
            ma0     = i_start_y;
            mi0     = i_start_x;
            ma1     = i_end_y;
            mi1     = i_end_x;
            d_major = abs_y;
            d_minor = abs_x;
        end else begin
            ma0     = i_start_x;
            mi0     = i_start_y;
            ma1     = i_end_x;
            mi1     = i_end_y;
            d_major = abs_x;
            d_minor = abs_y;
        end
    end

    // Walk the major axis upward.
    assign swap         = ma0 > ma1;
    assign o_cur_major  = swap ? ma1 : ma0;
    assign o_stop_major = swap ? ma0 : ma1;
    assign mi_first     = swap ? mi1 : mi0;
    assign mi_stop      = swap ? mi0 : mi1;
    assign o_cur_minor  = mi_first;

    always_comb begin
        o_ctrl.y_major = y_major;
        if (mi_stop > mi_first) begin
            o_ctrl.minor_dir = DIR_INC;
        end else if (mi_stop < mi_first) begin
            o_ctrl.minor_dir = DIR_DEC;
        end else begin
            o_ctrl.minor_dir = DIR_NONE;
        end
    end

    assign o_err_limit = d_major + ERR_W'(1);
    assign o_err_inc   = d_minor + ERR_W'(1);

endmodule

// ===== hw/rtl/line_rasterizer.sv =====
// Line rasterizer, top level.
// Takes a command on i_cmd and returns pixels on o_pix, both valid/ready
// channels; a transfer happens on a clock edge with valid and ready high.
// A load command (op = OP_LOAD) latches two endpoints and a colour and
// returns nothing; a load during a line drops that line and starts anew.
// Each step command (op = OP_STEP) during a line returns one pixel, in
// order from the lower major coordinate, last_pixel marking the endpoint.
// A step with no line loaded is taken and returns nothing.
// Latency: the pixel of a step is on o_pix the cycle after its transfer.
// Throughput: one command per cycle; each step is one add, one compare and
// one subtract on the error accumulator, all between two registers.
// The pixel register sits between the channels: i_cmd stays ready while it
// is empty or being drained, so a stalled receiver holds o_pix steady and
// holds off i_cmd only once a pixel waits.
// Reset (i_rst_n low, synchronous) clears the line-active flag and empties
// the pixel register; no clearing pass is needed.
// Depends on lr_pkg, lr_in_if, lr_pix_if, lr_setup and the defines header.
`include "line_rasterizer_defines.svh"

module line_rasterizer #(
    parameter int COORD_BITS = lr_pkg::LR_COORD_BITS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lr_in_if.sink     i_cmd,
    lr_pix_if.source  o_pix
);
    import lr_pkg::*;

    localparam int ERR_W = COORD_BITS + 1;
    localparam int ACC_W = COORD_BITS + 2;

    // Line state
    logic                         r_busy,       n_busy;
    t_line_ctrl                   r_ctrl,       n_ctrl;
    logic signed [COORD_BITS-1:0] r_cur_major,  n_cur_major;
    logic signed [COORD_BITS-1:0] r_cur_minor,  n_cur_minor;
    logic signed [COORD_BITS-1:0] r_stop_major, n_stop_major;
    logic [ACC_W-1:0]             r_err_acc,    n_err_acc;
    logic [ERR_W-1:0]             r_err_limit,  n_err_limit;
    logic [ERR_W-1:0]             r_err_inc,    n_err_inc;
    logic [LR_COLOUR_BITS-1:0]    r_colour,     n_colour;

    // Pixel register
    logic                         r_out_valid,  n_out_valid;
    logic signed [COORD_BITS-1:0] r_px,         n_px;
    logic signed [COORD_BITS-1:0] r_py,         n_py;
    logic [LR_COLOUR_BITS-1:0]    r_pcol,       n_pcol;
    logic                         r_plast,      n_plast;

    logic                         cmd_fire;
    logic                         load_fire;
    logic                         step_fire;
    logic                         is_last;
    logic [ACC_W-1:0]             acc_sum;
    logic                         acc_over;

    t_line_ctrl                   s_ctrl;
    logic signed [COORD_BITS-1:0] s_cur_major;
    logic signed [COORD_BITS-1:0] s_cur_minor;
    logic signed [COORD_BITS-1:0] s_stop_major;
    logic [ERR_W-1:0]             s_err_limit;
    logic [ERR_W-1:0]             s_err_inc;

    lr_setup #(
        .COORD_BITS (COORD_BITS)
    ) u_setup (
        .i_start_x    (i_cmd.start_x),
        .i_start_y    (i_cmd.start_y),
        .i_end_x      (i_cmd.end_x),
        .i_end_y      (i_cmd.end_y),
        .o_ctrl       (s_ctrl),
        .o_cur_major  (s_cur_major),
        .o_cur_minor  (s_cur_minor),
        .o_stop_major (s_stop_major),
        .o_err_limit  (s_err_limit),
        .o_err_inc    (s_err_inc)
    );

    assign i_cmd.ready = !r_out_valid || o_pix.ready;
    assign cmd_fire    = i_cmd.valid && i_cmd.ready;
    assign load_fire   = cmd_fire && (i_cmd.op == OP_LOAD);
    assign step_fire   = cmd_fire && (i_cmd.op == OP_STEP) && r_busy;

    assign is_last  = r_cur_major == r_stop_major;
    assign acc_sum  = r_err_acc + ACC_W'(r_err_inc);
    assign acc_over = acc_sum >= ACC_W'(r_err_limit);

    always_comb begin
        n_busy       = r_busy;
        n_ctrl       = r_ctrl;
        n_cur_major  = r_cur_major;
        n_cur_minor  = r_cur_minor;
        n_stop_major = r_stop_major;
        n_err_acc    = r_err_acc;
        n_err_limit  = r_err_limit;
        n_err_inc    = r_err_inc;
        n_colour     = r_colour;
        n_out_valid  = r_out_valid;
        n_px         = r_px;
        n_py         = r_py;
        n_pcol       = r_pcol;
        n_plast      = r_plast;

        if (o_pix.ready) begin
            n_out_valid = 1'b0;
        end

        if (load_fire) begin
            n_busy       = 1'b1;
            n_ctrl       = s_ctrl;
            n_cur_major  = s_cur_major;
            n_cur_minor  = s_cur_minor;
            n_stop_major = s_stop_major;
            n_err_limit  = s_err_limit;
            n_err_inc    = s_err_inc;
            n_err_acc    = ACC_W'(s_err_inc >> 1);
            n_colour     = i_cmd.colour;
        end else if (step_fire) begin
            n_out_valid = 1'b1;
            n_px        = r_ctrl.y_major ? r_cur_minor : r_cur_major;
            n_py        = r_ctrl.y_major ? r_cur_major : r_cur_minor;
            n_pcol      = r_colour;
            n_plast     = is_last;

            // Advance the error; on overflow step the minor axis.
            n_err_acc = acc_sum;
            if (acc_over) begin
                n_err_acc = acc_sum - ACC_W'(r_err_limit);
                case (r_ctrl.minor_dir)
                    DIR_INC: n_cur_minor = r_cur_minor + COORD_BITS'(1);
                    DIR_DEC: n_cur_minor = r_cur_minor - COORD_BITS'(1);
                    default: n_cur_minor = r_cur_minor;
                endcase
            end
            n_cur_major = r_cur_major + COORD_BITS'(1);
            if (is_last) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ctrl       <= n_ctrl;
        r_cur_major  <= n_cur_major;
        r_cur_minor  <= n_cur_minor;
        r_stop_major <= n_stop_major;
        r_err_acc    <= n_err_acc;
        r_err_limit  <= n_err_limit;
        r_err_inc    <= n_err_inc;
        r_colour     <= n_colour;
        r_px         <= n_px;
        r_py         <= n_py;
        r_pcol       <= n_pcol;
        r_plast      <= n_plast;
    end

    assign o_pix.valid        = r_out_valid;
    assign o_pix.pixel_x      = r_px;
    assign o_pix.pixel_y      = r_py;
    assign o_pix.pixel_colour = r_pcol;
    assign o_pix.last_pixel   = r_plast;

    `LR_ASSERT_IMPL(a_acc_below_limit, r_busy, r_err_acc < ACC_W'(r_err_limit), "acc at limit")
    `LR_ASSERT_IMPL(a_major_in_range, r_busy, r_cur_major <= r_stop_major, "major past line end")
    `LR_ASSERT_NEXT(a_step_emits, step_fire, r_out_valid, "step gave no pixel")

endmodule
